// ===== hw/rtl/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg: shared definitions for the submatrix match counter
// Field widths, configuration register indexes and defaults for the sizes.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int PIX_W         = 32;
    localparam int CNT_W         = 12;
    localparam int COLS_W        = 7;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int OUT_DATA_W    = 16;
    localparam int TMPL_SIZE     = 2;
    localparam int LINE_WIDTH_DEF = 64;
    localparam int MAX_ROWS_DEF  = 64;

    localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
    localparam logic [COLS_W-1:0] COLS_RESET    = 7'd5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TMPL_R0C0   = 3'd0,
        CFG_TMPL_R0C1   = 3'd1,
        CFG_TMPL_R1C0   = 3'd2,
        CFG_TMPL_R1C1   = 3'd3,
        CFG_COLS_IN_USE = 3'd4
    } cfg_idx_t;

endpackage

// ===== hw/rtl/submatrix_match_counter_top.sv =====
// ----------------------------------------------------------------------------
// submatrix_match_counter_top: 2x2 template match counter on a raster stream
// Compares each 2x2 window of the incoming matrix with a configured template.
// ----------------------------------------------------------------------------
// The block takes one matrix element per clock cycle in row-major order and
// returns one registered result per element, holding the match flag for
// the window whose lower-right corner is that element and the saturating
// match count of the frame. The previous row lives in a line buffer RAM whose
// registered read is issued in advance for the next column, so elements
// stream at one per cycle; s_tready stays low in the cycle after each
// configuration write while that read is reissued under the new settings.
// A new element enters in the same cycle as a waiting result is taken, so a
// stall on the result side holds the input for as long as it lasts. Both
// ready outputs stay low while reset is held.
module submatrix_match_counter_top #(
    parameter int LINE_WIDTH = smc_pkg::LINE_WIDTH_DEF,
    parameter int MAX_ROWS   = smc_pkg::MAX_ROWS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [smc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [smc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smc_pkg::PIX_W-1:0]        s_tdata,   // [31:0] pixel_value
    input  logic                             s_tlast,   // end_of_frame
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smc_pkg::OUT_DATA_W-1:0]   m_tdata,   // [11:0] match_count, rest zero
    output logic                             m_tuser,   // window_match
    output logic                             m_tlast    // frame_done
);

    import smc_pkg::*;

    localparam int COL_W = $clog2(LINE_WIDTH);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int WID_W = ($clog2(LINE_WIDTH + 1) > COLS_W) ?
                           $clog2(LINE_WIDTH + 1) : COLS_W;

    // Configuration registers
    logic [PIX_W-1:0]  t00_reg, t01_reg, t10_reg, t11_reg;
    logic [COLS_W-1:0] cols_reg;
    logic              cfg_wr_reg;

    // Frame state
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  left_reg, left_next;
    logic [PIX_W-1:0]  ul_reg, ul_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register
    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_cnt_reg;
    logic              m_match_reg;
    logic              m_last_reg;

    logic              cfg_fire;
    logic              in_fire;
    logic [WID_W-1:0]  width_eff;
    logic [COL_W-1:0]  col_cur;
    logic              col_last;
    logic [COL_W-1:0]  col_adv;
    logic [COL_W-1:0]  rd_addr;
    logic [PIX_W-1:0]  upper_pix;
    logic              match;
    logic [CNT_W-1:0]  cnt_out;

    assign cfg_ready = aresetn;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_tready  = aresetn & (~m_valid_reg | m_tready) & ~cfg_wr_reg;
    assign in_fire   = s_tvalid & s_tready;

    // Row width limited to the template size and the line buffer depth.
    always_comb begin
        if (WID_W'(cols_reg) < WID_W'(TMPL_SIZE)) begin
            width_eff = WID_W'(TMPL_SIZE);
        end else if (WID_W'(cols_reg) > WID_W'(LINE_WIDTH)) begin
            width_eff = WID_W'(LINE_WIDTH);
        end else begin
            width_eff = WID_W'(cols_reg);
        end
    end

    // A width lowered mid-row pins the column to the last one, ending the row.
    always_comb begin
        if (WID_W'(col_reg) >= width_eff) begin
            col_cur = COL_W'(width_eff - WID_W'(1));
        end else begin
            col_cur = col_reg;
        end
        col_last = (WID_W'(col_cur) + WID_W'(1)) >= width_eff;
        col_adv  = (s_tlast | col_last) ? '0 : col_cur + COL_W'(1);
        rd_addr  = in_fire ? col_adv : col_cur;
    end

    smc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (col_cur),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (upper_pix)
    );

    always_comb begin
        match = (row_reg != '0) && (col_cur != '0) &&
                (ul_reg == t00_reg) && (upper_pix == t01_reg) &&
                (left_reg == t10_reg) && (s_tdata == t11_reg);
        cnt_out = (match && cnt_reg != COUNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;

        col_next  = col_adv;
        row_next  = row_reg;
        left_next = s_tdata;
        ul_next   = upper_pix;
        cnt_next  = cnt_out;
        if (s_tlast) begin
            row_next  = '0;
            left_next = '0;
            ul_next   = '0;
            cnt_next  = '0;
        end else if (col_last) begin
            left_next = '0;
            ul_next   = '0;
            if (row_reg != ROW_W'(MAX_ROWS - 1)) begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t00_reg    <= '0;
            t01_reg    <= '0;
            t10_reg    <= '0;
            t11_reg    <= '0;
            cols_reg   <= COLS_RESET;
            cfg_wr_reg <= 1'b0;
        end else begin
            cfg_wr_reg <= cfg_fire;
            if (cfg_fire) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_TMPL_R0C0:   t00_reg  <= cfg_data;
                    CFG_TMPL_R0C1:   t01_reg  <= cfg_data;
                    CFG_TMPL_R1C0:   t10_reg  <= cfg_data;
                    CFG_TMPL_R1C1:   t11_reg  <= cfg_data;
                    CFG_COLS_IN_USE: cols_reg <= cfg_data[COLS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
            ul_reg   <= '0;
            cnt_reg  <= '0;
        end else if (in_fire) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
            ul_reg   <= ul_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_cnt_reg   <= cnt_out;
            m_match_reg <= match;
            m_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_cnt_reg);
    assign m_tuser  = m_match_reg;
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    // The count only grows within a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !s_tlast |=> cnt_reg >= $past(cnt_reg))
        else $error("match count decreased inside a frame");

    // A frame end clears the count and the row position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tlast |=> cnt_reg == '0 && row_reg == '0 && col_reg == '0)
        else $error("frame state not cleared after end of frame");

    // No window can match on the first row or the first column of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && match |-> row_reg != '0 && col_cur != '0)
        else $error("match reported without a full window");

    // The line buffer read is reissued before the next element after a write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_fire |=> !s_tready)
        else $error("element accepted right after a configuration write");

    // A reported match is always reflected in the reported count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && match |=> m_cnt_reg != '0)
        else $error("match flagged with a zero count");
`endif

endmodule

// ===== hw/rtl/smc_ram.sv =====
// ----------------------------------------------------------------------------
// smc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
